// ===== rtl/core/qch_pkg.sv =====
// qch_pkg: shared types and quadrant sign tables for the quadrant hull block
// no dependencies
package qch_pkg;

  // result of one orientation test
  typedef struct packed {
    logic done;
    logic cw;
  } qch_cross_res_t;

  // quadrant sign tables, bit q set where the sign is negative
  localparam logic [3:0] QSX_NEG = 4'b0110;
  localparam logic [3:0] QSY_NEG = 4'b1100;
  localparam logic [3:0] QOX_NEG = 4'b1100;

endpackage

// ===== rtl/core/qch_extreme.sv =====
// qch_extreme: running eight extreme points of a point stream
// no package dependencies
module qch_extreme #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 upd,
  input  logic                 first,
  input  logic signed [CW-1:0] px,
  input  logic signed [CW-1:0] py,
  output logic signed [CW-1:0] ex_x [8],
  output logic signed [CW-1:0] ex_y [8]
);

  // four independent update groups: {0,7} {3,4} {1,2} {5,6}
  always_ff @(posedge clk) begin
    if (upd) begin
      if (first) begin
        for (int i = 0; i < 8; i++) begin
          ex_x[i] <= px;
          ex_y[i] <= py;
        end
      end else begin
        // right side
        if (px >= ex_x[0]) begin
          if (px == ex_x[0]) begin
            if (py > ex_y[0]) begin
              ex_x[0] <= px; ex_y[0] <= py;
            end else if (py < ex_y[7]) begin
              ex_x[7] <= px; ex_y[7] <= py;
            end
          end else begin
            ex_x[0] <= px; ex_y[0] <= py;
            ex_x[7] <= px; ex_y[7] <= py;
          end
        end
        // left side
        if (px <= ex_x[3]) begin
          if (px == ex_x[3]) begin
            if (py > ex_y[3]) begin
              ex_x[3] <= px; ex_y[3] <= py;
            end else if (py < ex_y[4]) begin
              ex_x[4] <= px; ex_y[4] <= py;
            end
          end else begin
            ex_x[3] <= px; ex_y[3] <= py;
            ex_x[4] <= px; ex_y[4] <= py;
          end
        end
        // top side
        if (py >= ex_y[1]) begin
          if (py == ex_y[1]) begin
            if (px < ex_x[2]) begin
              ex_x[2] <= px; ex_y[2] <= py;
            end else if (px > ex_x[1]) begin
              ex_x[1] <= px; ex_y[1] <= py;
            end
          end else begin
            ex_x[1] <= px; ex_y[1] <= py;
            ex_x[2] <= px; ex_y[2] <= py;
          end
        end
        // bottom side
        if (py <= ex_y[5]) begin
          if (py == ex_y[5]) begin
            if (px < ex_x[5]) begin
              ex_x[5] <= px; ex_y[5] <= py;
            end else if (px > ex_x[6]) begin
              ex_x[6] <= px; ex_y[6] <= py;
            end
          end else begin
            ex_x[5] <= px; ex_y[5] <= py;
            ex_x[6] <= px; ex_y[6] <= py;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/qch_cross.sv =====
// qch_cross: strict clockwise test of three points, one shared multiplier
// depends on qch_pkg
module qch_cross
  import qch_pkg::*;
#(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic signed [CW-1:0] x1,
  input  logic signed [CW-1:0] y1,
  input  logic signed [CW-1:0] x2,
  input  logic signed [CW-1:0] y2,
  input  logic signed [CW-1:0] x3,
  input  logic signed [CW-1:0] y3,
  output qch_cross_res_t       res
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic [1:0]           step_r;
  logic signed [DW-1:0] a_r, b_r, c_r, d_r;
  logic signed [DW-1:0] op_a, op_b;
  logic signed [PW-1:0] m1_r, m2_r;
  logic signed [PW-1:0] prod;
  logic                 done_r, cw_r;

  // one multiplier, operands picked by step
  assign op_a = (step_r == 2'd1) ? a_r : c_r;
  assign op_b = (step_r == 2'd1) ? b_r : d_r;
  assign prod = PW'(op_a) * PW'(op_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (step_r)
        2'd0: if (go) step_r <= 2'd1;
        2'd1: step_r <= 2'd2;
        2'd2: step_r <= 2'd3;
        2'd3: begin
          done_r <= 1'b1;
          step_r <= 2'd0;
        end
        default: step_r <= 2'd0;
      endcase
    end
  end

  // operand and product registers
  always_ff @(posedge clk) begin
    if (step_r == 2'd0 && go) begin
      a_r <= DW'(x2) - DW'(x1);
      b_r <= DW'(y3) - DW'(y1);
      c_r <= DW'(x3) - DW'(x1);
      d_r <= DW'(y2) - DW'(y1);
    end
    if (step_r == 2'd1) m1_r <= prod;
    if (step_r == 2'd2) m2_r <= prod;
    if (step_r == 2'd3) cw_r <= m1_r < m2_r;
  end

  assign res.done = done_r;
  assign res.cw   = cw_r;

endmodule

// ===== rtl/core/quadrant_convex_hull.sv =====
// quadrant_convex_hull: top level, point store, hull store and sequencer
// depends on qch_pkg, qch_extreme, qch_cross
//
// channel  ports                          handshake
// input    in_point_x/y, in_last_point    start & !busy
// result   out_hull_x/y, out_last_out,    out_valid, one cycle, no stall
//          out_overflow
// config   cfg_data                       cfg_we
//
// A word without in_last_point is stored unless the store is full; busy
// stays low. A last word starts the run: an extreme pass over the points,
// seeding of the quadrants, a hull pass over the points with quadrant
// checks, binary search and orientation tests (shared multiplier unit), then
// the hull words. Reset clears counts and overflow, sets the close flag;
// busy is high for the whole run and the receiver cannot stall results.
module quadrant_convex_hull
  import qch_pkg::*;
#(
  parameter int MAX_POINTS  = 4096,
  parameter int HULL_DEPTH  = 15,
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  input  logic        in_last_point,
  input  logic        cfg_we,
  input  logic        cfg_data,
  output logic        out_valid,
  output logic [31:0] out_hull_x,
  output logic [31:0] out_hull_y,
  output logic        out_last_out,
  output logic        out_overflow
);

  localparam int CW   = COORD_WIDTH;
  localparam int PA_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PC_W = $clog2(MAX_POINTS + 1);
  localparam int HD_N = 4 * HULL_DEPTH;
  localparam int HA_W = $clog2(HD_N);
  localparam int HI_W = $clog2(HULL_DEPTH + 1);
  localparam int RW   = $clog2(HD_N + 2);

  typedef enum logic [4:0] {
    S_IDLE, S_EX_RD, S_EX_UPD, S_INIT, S_PT_RD, S_PT_LD, S_Q_CHK, S_QNEXT,
    S_BS_CHK, S_BS_CMP, S_BS_END, S_RT_A, S_RT_B, S_RT_W, S_LO_CHK, S_LO_RD,
    S_LO_W, S_HI_CHK, S_HI_RD, S_HI_W, S_UPD, S_INS_CHK, S_INS_WR, S_RM_CHK,
    S_RM_WR, S_NEXT, S_EM_PRE, S_EM_CAP, S_EM_SUM, S_EM_CHK, S_EM_OUT, S_DONE
  } state_t;

  state_t state_r;

  logic [PC_W-1:0]   pt_cnt_r, idx_r;
  logic              ovf_r, close_r;
  logic [2:0]        k_r;
  logic [1:0]        q_r;
  logic signed [CW-1:0] p_x_r, p_y_r;
  logic [HI_W-1:0]   lo_r, hi_r, j_r, dst_r;
  logic [HI_W-1:0]   hcnt_r [4];
  logic [2*CW-1:0]   lp_r, hp_r, t_r, first_r;
  logic [2*CW-1:0]   hf_r [4];
  logic [2*CW-1:0]   ht_r [4];
  logic [3:0]        qs_r;
  logic [RW-1:0]     rem_r;
  logic              seen_r;
  logic              cgo_r;
  logic [2*CW-1:0]   c1_r, c2_r, c3_r;
  logic              out_valid_r, out_last_r, out_ovf_r;
  logic [2*CW-1:0]   out_pt_r;

  // point store
  logic [2*CW-1:0] pmem [MAX_POINTS];
  logic [2*CW-1:0] pm_q;
  logic            acc;

  // hull store
  logic [2*CW-1:0] hmem [HD_N];
  logic [2*CW-1:0] hrd_q;
  logic [HA_W-1:0] hrd_a, hwr_a;
  logic [2*CW-1:0] hwr_d;
  logic            hwe;

  logic signed [CW-1:0] ex_x [8];
  logic signed [CW-1:0] ex_y [8];
  qch_cross_res_t       cres;

  function automatic logic [HA_W-1:0] haddr(input logic [1:0] q,
                                            input logic [HI_W-1:0] j);
    haddr = HA_W'(q) * HA_W'(HULL_DEPTH) + HA_W'(j);
  endfunction

  function automatic logic signed [CW-1:0] px_of(input logic [2*CW-1:0] v);
    px_of = v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] py_of(input logic [2*CW-1:0] v);
    py_of = v[2*CW-1:CW];
  endfunction

  assign busy = (state_r != S_IDLE);
  assign acc  = start && !busy;

  // point store access
  always_ff @(posedge clk) begin
    if (acc && pt_cnt_r < PC_W'(MAX_POINTS))
      pmem[pt_cnt_r[PA_W-1:0]] <= {in_point_y[CW-1:0], in_point_x[CW-1:0]};
    pm_q <= pmem[idx_r[PA_W-1:0]];
  end

  // hull store access
  always_ff @(posedge clk) begin
    if (hwe) hmem[hwr_a] <= hwr_d;
    hrd_q <= hmem[hrd_a];
  end

  qch_extreme #(.CW(CW)) u_ext (
    .clk  (clk),
    .upd  (state_r == S_EX_UPD),
    .first(idx_r == '0),
    .px   (px_of(pm_q)),
    .py   (py_of(pm_q)),
    .ex_x (ex_x),
    .ex_y (ex_y)
  );

  qch_cross #(.CW(CW)) u_cross (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cgo_r),
    .x1   (px_of(c1_r)), .y1(py_of(c1_r)),
    .x2   (px_of(c2_r)), .y2(py_of(c2_r)),
    .x3   (px_of(c3_r)), .y3(py_of(c3_r)),
    .res  (cres)
  );

  // derived values of the current quadrant
  logic [HI_W-1:0]      n_cur, mid;
  logic signed [CW-1:0] rx, ry;
  logic                 quad_in, xgt, xlt, ygt, ylt, sxp, syp, oxp, oxn;
  logic [3:0]           qs_c;
  logic [RW-1:0]        tot_c;

  assign n_cur = hcnt_r[q_r];
  assign mid   = lo_r + ((hi_r - lo_r) >> 1);

  // quadrant roots
  always_comb begin
    case (q_r)
      2'd0:    begin rx = ex_x[1]; ry = ex_y[0]; end
      2'd1:    begin rx = ex_x[2]; ry = ex_y[3]; end
      2'd2:    begin rx = ex_x[5]; ry = ex_y[4]; end
      default: begin rx = ex_x[6]; ry = ex_y[7]; end
    endcase
  end

  assign quad_in = (QSX_NEG[q_r] ? (p_x_r < rx) : (p_x_r > rx)) &&
                   (QSY_NEG[q_r] ? (p_y_r < ry) : (p_y_r > ry));

  // position against the hull point under search
  assign xgt = p_x_r > px_of(hrd_q);
  assign xlt = p_x_r < px_of(hrd_q);
  assign ygt = p_y_r > py_of(hrd_q);
  assign ylt = p_y_r < py_of(hrd_q);
  assign sxp = QSX_NEG[q_r] ? xlt : xgt;
  assign syp = QSY_NEG[q_r] ? ylt : ygt;
  assign oxp = QOX_NEG[q_r] ? xlt : xgt;
  assign oxn = QOX_NEG[q_r] ? xgt : xlt;

  // duplicate skips at quadrant joins and output total
  always_comb begin
    qs_c[0] = (hf_r[0] == ht_r[3]);
    qs_c[1] = (hf_r[1] == ht_r[0]);
    qs_c[2] = (hf_r[2] == ht_r[1]);
    qs_c[3] = (hf_r[3] == ht_r[2]);
    tot_c = RW'(hcnt_r[0]) + RW'(hcnt_r[1]) + RW'(hcnt_r[2]) + RW'(hcnt_r[3])
          - RW'($countones(qs_c));
  end

  // hull store address and write selection
  always_comb begin
    hrd_a = '0;
    hwe   = 1'b0;
    hwr_a = '0;
    hwr_d = {p_y_r, p_x_r};
    unique case (state_r)
      S_BS_CHK:  hrd_a = haddr(q_r, mid);
      S_BS_END:  hrd_a = haddr(q_r, lo_r);
      S_RT_A:    hrd_a = haddr(q_r, hi_r);
      S_LO_CHK:  hrd_a = haddr(q_r, lo_r - 1'b1);
      S_HI_CHK:  hrd_a = haddr(q_r, hi_r + 1'b1);
      S_INS_CHK: begin
        hrd_a = haddr(q_r, j_r - 1'b1);
        if (j_r <= hi_r) begin
          hwe   = 1'b1;
          hwr_a = haddr(q_r, hi_r);
        end
      end
      S_INS_WR: begin
        hwe   = 1'b1;
        hwr_a = haddr(q_r, j_r);
        hwr_d = hrd_q;
      end
      S_UPD: begin
        if (HI_W'(lo_r + 1'b1) != hi_r) begin
          hwe   = 1'b1;
          hwr_a = haddr(q_r, lo_r + 1'b1);
        end
      end
      S_RM_CHK:  hrd_a = haddr(q_r, j_r);
      S_RM_WR: begin
        hwe   = 1'b1;
        hwr_a = haddr(q_r, dst_r);
        hwr_d = hrd_q;
      end
      S_INIT: begin
        hwe   = !k_r[0] || ({ex_y[k_r - 3'd1], ex_x[k_r - 3'd1]} != {ex_y[k_r], ex_x[k_r]});
        hwr_a = haddr(k_r[2:1], HI_W'(k_r[0]));
        hwr_d = {ex_y[k_r], ex_x[k_r]};
      end
      S_EM_PRE:  hrd_a = haddr(k_r[2:1], k_r[0] ? hcnt_r[k_r[2:1]] - 1'b1 : '0);
      S_EM_CHK:  hrd_a = haddr(q_r, j_r);
      default:   hrd_a = '0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pt_cnt_r    <= '0;
      idx_r       <= '0;
      ovf_r       <= 1'b0;
      close_r     <= 1'b1;
      cgo_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) hcnt_r[i] <= '0;
    end else begin
      cgo_r       <= 1'b0;
      out_valid_r <= 1'b0;
      if (cfg_we) close_r <= cfg_data;
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            if (pt_cnt_r < PC_W'(MAX_POINTS)) pt_cnt_r <= pt_cnt_r + 1'b1;
            else ovf_r <= 1'b1;
            if (in_last_point) begin
              idx_r   <= '0;
              state_r <= S_EX_RD;
            end
          end
        end
        S_EX_RD: state_r <= S_EX_UPD;
        S_EX_UPD: begin
          if ((PC_W + 1)'(idx_r) + 1'b1 < (PC_W + 1)'(pt_cnt_r)) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_EX_RD;
          end else begin
            idx_r   <= '0;
            k_r     <= '0;
            state_r <= S_INIT;
          end
        end
        // seed each quadrant with its two extremes
        S_INIT: begin
          if (k_r[0])
            hcnt_r[k_r[2:1]] <= ({ex_y[k_r - 3'd1], ex_x[k_r - 3'd1]} ==
                                 {ex_y[k_r], ex_x[k_r]}) ? HI_W'(1) : HI_W'(2);
          k_r <= k_r + 1'b1;
          if (k_r == 3'd7) state_r <= S_PT_RD;
        end
        S_PT_RD: state_r <= S_PT_LD;
        S_PT_LD: begin
          p_x_r   <= px_of(pm_q);
          p_y_r   <= py_of(pm_q);
          q_r     <= 2'd0;
          state_r <= S_Q_CHK;
        end
        S_Q_CHK: begin
          if (!quad_in || n_cur < HI_W'(2)) begin
            state_r <= S_QNEXT;
          end else begin
            lo_r    <= '0;
            hi_r    <= n_cur;
            state_r <= S_BS_CHK;
          end
        end
        S_QNEXT: begin
          if (q_r == 2'd3) state_r <= S_NEXT;
          else begin
            q_r     <= q_r + 1'b1;
            state_r <= S_Q_CHK;
          end
        end
        // binary search for the insertion place
        S_BS_CHK: begin
          if ((HI_W + 1)'(lo_r) + 1'b1 < (HI_W + 1)'(hi_r)) begin
            j_r     <= mid;
            state_r <= S_BS_CMP;
          end else state_r <= S_BS_END;
        end
        S_BS_CMP: begin
          if (!sxp && !syp) state_r <= S_QNEXT;
          else if (oxp) begin
            hi_r    <= j_r;
            state_r <= S_BS_CHK;
          end else if (oxn) begin
            lo_r    <= j_r;
            state_r <= S_BS_CHK;
          end else begin
            lo_r    <= j_r - 1'b1;
            hi_r    <= j_r + 1'b1;
            state_r <= S_BS_END;
          end
        end
        S_BS_END: state_r <= (hi_r >= n_cur) ? S_QNEXT : S_RT_A;
        S_RT_A: begin
          lp_r    <= hrd_q;
          state_r <= S_RT_B;
        end
        S_RT_B: begin
          hp_r    <= hrd_q;
          c1_r    <= lp_r;
          c2_r    <= hrd_q;
          c3_r    <= {p_y_r, p_x_r};
          cgo_r   <= 1'b1;
          state_r <= S_RT_W;
        end
        S_RT_W: if (cres.done) state_r <= cres.cw ? S_LO_CHK : S_QNEXT;
        // widen the range downward
        S_LO_CHK: state_r <= (lo_r != '0) ? S_LO_RD : S_HI_CHK;
        S_LO_RD: begin
          t_r     <= hrd_q;
          c1_r    <= hrd_q;
          c2_r    <= {p_y_r, p_x_r};
          c3_r    <= lp_r;
          cgo_r   <= 1'b1;
          state_r <= S_LO_W;
        end
        S_LO_W: begin
          if (cres.done) begin
            if (!cres.cw) begin
              lo_r    <= lo_r - 1'b1;
              lp_r    <= t_r;
              state_r <= S_LO_CHK;
            end else state_r <= S_HI_CHK;
          end
        end
        // widen the range upward
        S_HI_CHK:
          state_r <= ((HI_W + 1)'(hi_r) + 1'b1 < (HI_W + 1)'(n_cur)) ? S_HI_RD : S_UPD;
        S_HI_RD: begin
          t_r     <= hrd_q;
          c1_r    <= {p_y_r, p_x_r};
          c2_r    <= hrd_q;
          c3_r    <= hp_r;
          cgo_r   <= 1'b1;
          state_r <= S_HI_W;
        end
        S_HI_W: begin
          if (cres.done) begin
            if (!cres.cw) begin
              hi_r    <= hi_r + 1'b1;
              hp_r    <= t_r;
              state_r <= S_HI_CHK;
            end else state_r <= S_UPD;
          end
        end
        // insert, replace or remove
        S_UPD: begin
          if (HI_W'(lo_r + 1'b1) == hi_r) begin
            if (n_cur >= HI_W'(HULL_DEPTH)) begin
              ovf_r   <= 1'b1;
              state_r <= S_NEXT;
            end else begin
              j_r     <= n_cur;
              state_r <= S_INS_CHK;
            end
          end else if ((HI_W + 1)'(lo_r) + 2'd2 < (HI_W + 1)'(hi_r)) begin
            j_r     <= hi_r;
            dst_r   <= lo_r + 2'd2;
            state_r <= S_RM_CHK;
          end else state_r <= S_NEXT;
        end
        S_INS_CHK: begin
          if (j_r > hi_r) state_r <= S_INS_WR;
          else begin
            hcnt_r[q_r] <= n_cur + 1'b1;
            state_r     <= S_NEXT;
          end
        end
        S_INS_WR: begin
          j_r     <= j_r - 1'b1;
          state_r <= S_INS_CHK;
        end
        S_RM_CHK: begin
          if (j_r < n_cur) state_r <= S_RM_WR;
          else begin
            hcnt_r[q_r] <= dst_r;
            state_r     <= S_NEXT;
          end
        end
        S_RM_WR: begin
          j_r     <= j_r + 1'b1;
          dst_r   <= dst_r + 1'b1;
          state_r <= S_RM_CHK;
        end
        S_NEXT: begin
          if ((PC_W + 1)'(idx_r) + 1'b1 < (PC_W + 1)'(pt_cnt_r)) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_PT_RD;
          end else begin
            k_r     <= '0;
            state_r <= S_EM_PRE;
          end
        end
        // gather first and last point of each quadrant
        S_EM_PRE: state_r <= S_EM_CAP;
        S_EM_CAP: begin
          if (k_r[0]) ht_r[k_r[2:1]] <= hrd_q;
          else hf_r[k_r[2:1]] <= hrd_q;
          k_r     <= k_r + 1'b1;
          state_r <= (k_r == 3'd7) ? S_EM_SUM : S_EM_PRE;
        end
        S_EM_SUM: begin
          if (tot_c <= RW'(1)) begin
            out_valid_r <= 1'b1;
            out_pt_r    <= ht_r[3];
            out_last_r  <= 1'b1;
            out_ovf_r   <= ovf_r;
            state_r     <= S_DONE;
          end else begin
            qs_r    <= qs_c;
            rem_r   <= tot_c;
            q_r     <= 2'd0;
            j_r     <= HI_W'(qs_c[0]);
            seen_r  <= 1'b0;
            state_r <= S_EM_CHK;
          end
        end
        S_EM_CHK: begin
          if (j_r >= n_cur) begin
            if (q_r == 2'd3) begin
              if (close_r) begin
                out_valid_r <= 1'b1;
                out_pt_r    <= first_r;
                out_last_r  <= 1'b1;
                out_ovf_r   <= ovf_r;
              end
              state_r <= S_DONE;
            end else begin
              q_r <= q_r + 1'b1;
              j_r <= HI_W'(qs_r[q_r + 2'd1]);
            end
          end else state_r <= S_EM_OUT;
        end
        S_EM_OUT: begin
          out_valid_r <= 1'b1;
          out_pt_r    <= hrd_q;
          out_last_r  <= (rem_r == RW'(1)) && !close_r;
          out_ovf_r   <= ovf_r;
          rem_r       <= rem_r - 1'b1;
          if (!seen_r) begin
            first_r <= hrd_q;
            seen_r  <= 1'b1;
          end
          j_r     <= j_r + 1'b1;
          state_r <= S_EM_CHK;
        end
        S_DONE: begin
          pt_cnt_r <= '0;
          ovf_r    <= 1'b0;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hull_x   = 32'(px_of(out_pt_r));
  assign out_hull_y   = 32'(py_of(out_pt_r));
  assign out_last_out = out_last_r;
  assign out_overflow = out_ovf_r;

  // the final word of a run is never followed directly by another
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_out |=> !out_valid)
    else $error("word right after final hull word");

  // no result words while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !out_valid)
    else $error("result word while idle");

  // quadrant hull counts stay within the store
  a_hcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r[0] <= HI_W'(HULL_DEPTH) && hcnt_r[1] <= HI_W'(HULL_DEPTH) &&
    hcnt_r[2] <= HI_W'(HULL_DEPTH) && hcnt_r[3] <= HI_W'(HULL_DEPTH))
    else $error("quadrant hull count out of range");

endmodule
